>>> sv/ita_pkg.sv
// Shared types, constants and the digit-to-ASCII helper of the integer to ASCII formatter.
// No dependencies; the formatter and its testbench import it.
package ita_pkg;

  typedef enum logic [2:0] {
    OP_SDEC32 = 3'd0,
    OP_UDEC32 = 3'd1,
    OP_LHEX32 = 3'd2,
    OP_UHEX32 = 3'd3,
    OP_LHEX64 = 3'd4
  } op_e;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned NibW     = 4;
  localparam int unsigned BcdDigs  = 10;
  localparam int unsigned BcdW     = BcdDigs * NibW;
  localparam int unsigned Hex32Digs = WordW / NibW;
  localparam int unsigned Hex64Digs = ValueW / NibW;
  localparam int unsigned CntW     = 5;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [NibW-1:0] Radix = NibW'(10);

  typedef logic [ValueW-1:0] digits_t;

  function automatic logic [7:0] nib_to_ascii(input logic [NibW-1:0] nib, input logic upper);
    logic [7:0] base;
    begin
      if (nib < Radix) begin
        nib_to_ascii = CharZero + {4'b0, nib};
      end else begin
        base = upper ? CharUpA : CharLowA;
        nib_to_ascii = base + {4'b0, nib - Radix};
      end
    end
  endfunction

endpackage

>>> sv/ita_if.sv
// Valid/ready channel interfaces of the integer to ASCII formatter.
// Depends on nothing but plain logic types.
interface ita_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface ita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

>>> sv/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: one number in, its decimal or hex characters out.
// Depends on ita_pkg and the channel interfaces in ita_if.sv.
//
//  channel  | dir | beat payload                | note
//  in_i     | in  | operation[2:0], value[63:0] | one number per beat
//  out_o    | out | character[7:0], last        | one character per beat
//
// Hex: after the accept, each digit position (8 or 16) in turn either skips a
// leading zero or sends a character; the last position is always sent.
// Decimal: after the accept, 32 steps of shift-and-add-3 in the shared BCD
// register, then a '-' if negative, then the 10 BCD digit positions as for hex.
// in_i.ready is high only while idle, where unused codes are dropped in the
// accept cycle; a stalled out_o holds its character. Reset returns to idle.
module integer_to_ascii_formatter
  import ita_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ita_in_if.sink    in_i,
  ita_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             started_q, started_d;
  logic             upper_q, upper_d;
  logic [WordW-1:0] bin_q, bin_d;
  digits_t          dig_q, dig_d;

  logic [WordW-1:0] low32;
  logic [WordW-1:0] mag;
  logic             is_neg;
  logic [BcdW-1:0]  bcd_adj;
  logic [BcdW-1:0]  bcd_shift;
  logic [NibW-1:0]  top_nib;
  logic             skip;
  logic             in_fire;
  logic             out_fire;

  assign low32   = in_i.value[WordW-1:0];
  assign is_neg  = (in_i.operation == OP_SDEC32) && low32[WordW-1];
  assign mag     = is_neg ? (~low32 + WordW'(1)) : low32;
  assign top_nib = dig_q[ValueW-1 -: NibW];

  // Shared shift-and-add-3 step: adjust every BCD digit, then shift one bit in.
  always_comb begin
    bcd_adj = dig_q[BcdW-1:0];
    for (int i = 0; i < BcdDigs; i++) begin
      if (bcd_adj[i*NibW +: NibW] >= NibW'(5)) begin
        bcd_adj[i*NibW +: NibW] = bcd_adj[i*NibW +: NibW] + NibW'(3);
      end
    end
    bcd_shift = {bcd_adj[BcdW-2:0], bin_q[WordW-1]};
  end

  assign skip = (state_q == ST_EMIT) && !started_q && (top_nib == '0) &&
                (cnt_q != CntW'(1));

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_SIGN) || ((state_q == ST_EMIT) && !skip);
  assign out_o.character = (state_q == ST_SIGN) ? CharMinus : nib_to_ascii(top_nib, upper_q);
  assign out_o.last      = (state_q == ST_EMIT) && (cnt_q == CntW'(1));

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    upper_d   = upper_q;
    bin_d     = bin_q;
    dig_d     = dig_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          started_d = 1'b0;
          upper_d   = (in_i.operation == OP_UHEX32);
          bin_d     = mag;
          unique case (in_i.operation)
            OP_SDEC32, OP_UDEC32: begin
              dig_d   = '0;
              cnt_d   = CntW'(WordW - 1);
              state_d = ST_CONV;
              upper_d = is_neg; // remember the sign until conversion ends
            end
            OP_LHEX32, OP_UHEX32: begin
              dig_d   = {low32, {(ValueW-WordW){1'b0}}};
              cnt_d   = CntW'(Hex32Digs);
              state_d = ST_EMIT;
            end
            OP_LHEX64: begin
              dig_d   = in_i.value;
              cnt_d   = CntW'(Hex64Digs);
              state_d = ST_EMIT;
            end
            default: begin
              state_d = ST_IDLE; // drop unused codes
            end
          endcase
        end
      end
      ST_CONV: begin
        bin_d = {bin_q[WordW-2:0], 1'b0};
        if (cnt_q == '0) begin
          dig_d   = {bcd_shift, {(ValueW-BcdW){1'b0}}};
          cnt_d   = CntW'(BcdDigs);
          upper_d = 1'b0;
          state_d = upper_q ? ST_SIGN : ST_EMIT;
        end else begin
          dig_d = {{(ValueW-BcdW){1'b0}}, bcd_shift};
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_SIGN: begin
        if (out_fire) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip || out_fire) begin
          dig_d = {dig_q[ValueW-NibW-1:0], {NibW{1'b0}}};
          cnt_d = cnt_q - CntW'(1);
          if (out_fire) begin
            started_d = 1'b1;
            if (cnt_q == CntW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q <= upper_d;
    bin_q   <= bin_d;
    dig_q   <= dig_d;
  end

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after last character");

  a_conv_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !out_o.valid)
    else $error("character shown during conversion");

  a_bad_op_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.operation != OP_SDEC32 && in_i.operation != OP_UDEC32 &&
     in_i.operation != OP_LHEX32 && in_i.operation != OP_UHEX32 &&
     in_i.operation != OP_LHEX64) |=> (state_q == ST_IDLE))
    else $error("unused operation code not dropped");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0 && cnt_q <= CntW'(Hex64Digs)))
    else $error("digit count out of range while emitting");

  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN && out_fire) |=> (state_q == ST_EMIT && !started_q))
    else $error("sign not followed by digits");

endmodule

>>> test/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of integer_to_ascii_formatter: numbers in, ASCII characters out.
// Depends on ita_pkg, the channel interfaces in ita_if.sv and the block itself.
module integer_to_ascii_formatter_tb
  import ita_pkg::*;
();

  localparam int unsigned LimitCycles  = 400_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles   = 80;
  localparam int unsigned MaxShown     = 10;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  class digit_string_checker;
    char_beat_t pending_chars[$];
    int unsigned mismatches = 0;

    // Work out the characters of one accepted number and queue them.
    function void take_number(logic [2:0] op, logic [63:0] value);
      logic [63:0] mag;
      logic [3:0]  d;
      logic [7:0]  digs[$];
      int unsigned radix;
      bit          upper;
      bit          neg;
      char_beat_t  beat;
      upper = 1'b0;
      neg   = 1'b0;
      radix = 16;
      mag   = {32'b0, value[31:0]};
      case (op)
        OP_SDEC32: begin
          radix = 10;
          if (value[31]) begin
            neg = 1'b1;
            mag = {32'b0, -value[31:0]};
          end
        end
        OP_UDEC32: radix = 10;
        OP_LHEX32: radix = 16;
        OP_UHEX32: upper = 1'b1;
        OP_LHEX64: mag = value;
        default: return;
      endcase
      do begin
        d = 4'(mag % radix);
        if (d < 4'd10) digs.push_front(CharZero + 8'(d));
        else digs.push_front((upper ? CharUpA : CharLowA) + 8'(d) - 8'd10);
        mag = mag / radix;
      end while (mag != 0);
      if (neg) digs.push_front(CharMinus);
      foreach (digs[i]) begin
        beat.character = digs[i];
        beat.last      = (i == digs.size() - 1);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic lst);
      char_beat_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected character 0x%02h last=%0b", ch, lst);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.character || lst !== want.last) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("character mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                   want.character, want.last, ch, lst);
      end
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm = 1'b0;
  bit   hold_off_req = 1'b0;
  int unsigned cycles = 0;
  digit_string_checker sb;

  ita_in_if  in_if ();
  ita_out_if out_if ();

  integer_to_ascii_formatter DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Note accepted numbers before checking characters on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_number(in_if.operation, in_if.value);
      if (out_if.valid && out_if.ready) sb.check_char(out_if.character, out_if.last);
    end
  end

  // Receiver: random back-pressure, one calm stretch and one long hold-off.
  initial begin : char_sink
    int unsigned held;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 1; held < HoldOffCycles; held++) @(posedge clk_i);
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic offer_number(input logic [2:0] op, input logic [63:0] value);
    while (!calm && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= value;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0: v = v >> $urandom_range(63);
      1: v = {v[63:32], 32'($urandom_range(20))};
      2: v = {v[63:32], 32'h8000_0000 + 32'($urandom_range(20))};
      3: v = {v[63:32], 32'h7FFF_FFFF - 32'($urandom_range(20))};
      default: ;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int unsigned sent;
    logic [2:0]  op;
    sb = new();
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= '0;
    in_if.value     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed numbers: signed extremes including the most negative value, then unsigned and hex cases.
    offer_number(OP_SDEC32, 64'd0);
    offer_number(OP_SDEC32, 64'd1);
    offer_number(OP_SDEC32, 64'h0000_0000_FFFF_FFFF);
    offer_number(OP_SDEC32, 64'h0000_0000_7FFF_FFFF);
    offer_number(OP_SDEC32, 64'h0000_0000_8000_0000);
    offer_number(OP_SDEC32, 64'hDEAD_BEEF_8000_0001);
    offer_number(OP_SDEC32, 64'd9);
    offer_number(OP_SDEC32, 64'd10);
    offer_number(OP_UDEC32, 64'd0);
    offer_number(OP_UDEC32, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(OP_UDEC32, 64'd1_000_000_000);
    offer_number(OP_LHEX32, 64'd0);
    offer_number(OP_LHEX32, 64'h1234_5678_DEAD_BEEF);
    offer_number(OP_UHEX32, 64'h0000_0000_ABCD_EF09);
    offer_number(OP_UHEX32, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(OP_LHEX64, 64'd0);
    offer_number(OP_LHEX64, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(OP_LHEX64, 64'h0123_4567_89AB_CDEF);
    offer_number(OP_LHEX64, 64'h8000_0000_0000_0000);
    offer_number(OP_LHEX64, 64'hF);
    // Unused selector codes: dropped without output.
    offer_number(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(3'd6, 64'd0);
    offer_number(3'd7, 64'h5555_AAAA_5555_AAAA);

    sent = 0;
    while (sent < 320) begin
      if ($urandom_range(19) == 0) begin
        op = 3'($urandom_range(7, 5));
      end else begin
        op = 3'($urandom_range(4));
        sent++;
      end
      offer_number(op, random_value());
      if (sent == 120) calm = 1'b1;
      if (sent == 180 && calm) begin
        calm = 1'b0;
        hold_off_req = 1'b1;
      end
      if (sent == 240 && op <= OP_LHEX64) begin
        // Pause until every queued character has drained; the accepted beat
        // is noted on the edge just passed.
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
    @(posedge clk_i);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ita_pkg.sv
sv/ita_if.sv
sv/integer_to_ascii_formatter.sv
test/integer_to_ascii_formatter_tb.sv
